/* hdl/apsp_pkg.sv */
// Shared constants and controller/datapath interface types for the
// all-pairs shortest path core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package apsp_pkg;

	// Default and field widths
	localparam int MAX_NODES_DEF = 8;
	localparam int NODE_W        = 3;
	localparam int DIST_W        = 30;
	localparam int CFG_W         = 4;

	// Distance that marks a missing edge; sums saturate here
	localparam logic [DIST_W-1:0] NO_EDGE        = 30'd1000000000;
	localparam logic [CFG_W-1:0]  NODE_COUNT_RST = 4'd8;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;    // write one entry from the input request
		logic rd_a;    // read port 0 at (j,i) instead of (i,k)
		logic lat_a;   // capture d(j,i) for the current row
		logic upd;     // relax d(j,k) with the read operands
		logic out_ld;  // load output register from read port 1
		logic last;    // final entry of the emitted matrix
	} apsp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic out_take;  // output request taken this cycle
	} apsp_sts_t;

endpackage

`default_nettype wire

/* hdl/apsp_ctrl.sv */
// Sequencer for the all-pairs shortest path core: input handshake,
// relaxation loop counters and matrix readout. Uses apsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apsp_ctrl
	import apsp_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	localparam int IW = $clog2(MAX_NODES)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          in_mode,
	input  wire logic [IW-1:0] nm1,
	input  wire apsp_sts_t     sts,
	output apsp_cmd_t          cmd,
	output logic [IW-1:0]      idx_i,
	output logic [IW-1:0]      idx_j,
	output logic [IW-1:0]      idx_k
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RD_A   = 3'd1;
	localparam logic [2:0] S_LAT_A  = 3'd2;
	localparam logic [2:0] S_RD_BC  = 3'd3;
	localparam logic [2:0] S_UPD    = 3'd4;
	localparam logic [2:0] S_EM_RD  = 3'd5;
	localparam logic [2:0] S_EM_LD  = 3'd6;
	localparam logic [2:0] S_EM_WT  = 3'd7;

	logic [2:0]    state_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic          accept;
	logic          k_end, j_end, i_end;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;
	assign k_end    = (k_q == nm1);
	assign j_end    = (j_q == nm1);
	assign i_end    = (i_q == nm1);

	assign idx_i = i_q;
	assign idx_j = j_q;
	assign idx_k = k_q;

	// Command decode
	always_comb begin
		cmd        = '0;
		cmd.load   = accept & ~in_mode;
		cmd.rd_a   = (state_q == S_RD_A);
		cmd.lat_a  = (state_q == S_LAT_A);
		cmd.upd    = (state_q == S_UPD);
		cmd.out_ld = (state_q == S_EM_LD);
		cmd.last   = j_end & k_end;
	end

	// State and loop counters; j and k double as row and column on readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && in_mode) begin
						state_q <= S_RD_A;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
					end
				end
				S_RD_A:  state_q <= S_LAT_A;
				S_LAT_A: state_q <= S_RD_BC;
				S_RD_BC: state_q <= S_UPD;
				S_UPD: begin
					if (!k_end) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_RD_BC;
					end else begin
						k_q <= '0;
						if (!j_end) begin
							j_q     <= j_q + 1'b1;
							state_q <= S_RD_A;
						end else begin
							j_q <= '0;
							if (!i_end) begin
								i_q     <= i_q + 1'b1;
								state_q <= S_RD_A;
							end else begin
								i_q     <= '0;
								state_q <= S_EM_RD;
							end
						end
					end
				end
				S_EM_RD: state_q <= S_EM_LD;
				S_EM_LD: state_q <= S_EM_WT;
				S_EM_WT: begin
					if (sts.out_take) begin
						if (j_end && k_end) begin
							j_q     <= '0;
							k_q     <= '0;
							state_q <= S_IDLE;
						end else if (!k_end) begin
							k_q     <= k_q + 1'b1;
							state_q <= S_EM_RD;
						end else begin
							k_q     <= '0;
							j_q     <= j_q + 1'b1;
							state_q <= S_EM_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/apsp_dpath.sv */
// Datapath of the all-pairs shortest path core: distance memory with
// valid bits, node count register, saturating relax unit, output register.
// Uses apsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apsp_dpath
	import apsp_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	localparam int IW    = $clog2(MAX_NODES),
	localparam int DEPTH = MAX_NODES * MAX_NODES,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire apsp_cmd_t         cmd,
	output apsp_sts_t              sts,
	input  wire logic [IW-1:0]     idx_i,
	input  wire logic [IW-1:0]     idx_j,
	input  wire logic [IW-1:0]     idx_k,
	output logic [IW-1:0]          nm1,
	input  wire logic              cfg_we,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	input  wire logic [NODE_W-1:0] ld_row,
	input  wire logic [NODE_W-1:0] ld_col,
	input  wire logic [DIST_W-1:0] ld_weight,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [NODE_W-1:0]      out_src,
	output logic [NODE_W-1:0]      out_dst,
	output logic [DIST_W-1:0]      out_dist,
	output logic                   out_last
);

	localparam logic [CFG_W-1:0]  MAXN_C = CFG_W'(MAX_NODES);
	localparam logic [NODE_W:0]   MAXN_R = (NODE_W + 1)'(MAX_NODES);

	function automatic logic [AW-1:0] ent_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		ent_addr = AW'(AW'(r) * AW'(MAX_NODES) + AW'(c));
	endfunction

	logic [CFG_W-1:0]  ncount_q;
	logic [CFG_W-1:0]  nm1_full;
	logic [DIST_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [AW-1:0]     ra0, ra1, wa;
	logic [DIST_W-1:0] rd0_q, rd1_q, rd0, rd1, wd;
	logic              rv0_q, rv1_q, we;
	logic [DIST_W-1:0] a_q;
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] sat, wclamp;
	logic              relax_lt, ld_ok;

	// Node count register and its clamped last index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncount_q <= NODE_COUNT_RST;
		end else if (cfg_we) begin
			ncount_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (ncount_q == '0) begin
			nm1_full = '0;
		end else if (ncount_q > MAXN_C) begin
			nm1_full = MAXN_C - 1'b1;
		end else begin
			nm1_full = ncount_q - 1'b1;
		end
	end
	assign nm1 = nm1_full[IW-1:0];

	// Read addresses: port 0 gives d(j,i) or d(i,k), port 1 gives d(j,k)
	assign ra0 = cmd.rd_a ? ent_addr(idx_j, idx_i) : ent_addr(idx_i, idx_k);
	assign ra1 = ent_addr(idx_j, idx_k);

	// Saturating relax of d(j,k) through node i
	assign sum      = {1'b0, a_q} + {1'b0, rd0};
	assign sat      = (sum > {1'b0, NO_EDGE}) ? NO_EDGE : sum[DIST_W-1:0];
	assign relax_lt = (sat < rd1);

	// Load path: ignore out-of-range entries, clamp weight
	assign ld_ok  = ({1'b0, ld_row} < MAXN_R) && ({1'b0, ld_col} < MAXN_R);
	assign wclamp = (ld_weight > NO_EDGE) ? NO_EDGE : ld_weight;

	// Single write port shared by load and relax
	assign we = (cmd.load & ld_ok) | (cmd.upd & relax_lt);
	assign wa = cmd.load ? ent_addr(ld_row[IW-1:0], ld_col[IW-1:0]) : ra1;
	assign wd = cmd.load ? wclamp : sat;

	// Distance memory, registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
		rv0_q <= valid_q[ra0];
		rv1_q <= valid_q[ra1];
	end

	// Never-written entries read as no edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[wa] <= 1'b1;
		end
	end

	assign rd0 = rv0_q ? rd0_q : NO_EDGE;
	assign rd1 = rv1_q ? rd1_q : NO_EDGE;

	// Row operand d(j,i)
	always_ff @(posedge clk) begin
		if (cmd.lat_a) begin
			a_q <= rd0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_src  <= NODE_W'(idx_j);
			out_dst  <= NODE_W'(idx_k);
			out_dist <= rd1;
			out_last <= cmd.last;
		end
	end

	assign sts.out_take = out_valid & out_ready;

endmodule

`default_nettype wire

/* hdl/all_pairs_shortest_path_core.sv */
// Top level of the all-pairs shortest path (Floyd-Warshall) core; uses apsp_pkg,
// apsp_ctrl and apsp_dpath. Load request: taken back to back while idle.
// Compute request: for each i and j, d(j,i) is read and latched, then each d(j,k)
// is read and relaxed through node i; then n*n results, each read and loaded into
// the output register, held until taken; next request taken after the last result.
// Reset (arst_n low, asynchronous): idle, node count 8, all entries no edge.
`timescale 1ns / 1ps
`default_nettype none

module all_pairs_shortest_path_core
	import apsp_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// Configuration: node_count
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	// Input requests
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [39:0]      s_tdata,   // row[2:0], col[5:3], weight[35:6], zero
	input  wire logic [0:0]       s_tuser,   // mode
	// Results
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [39:0]           m_tdata,   // src_node[2:0], dst_node[5:3], distance[35:6], zero
	output logic                  m_tlast
);

	localparam int IW = $clog2(MAX_NODES);

	apsp_cmd_t         cmd;
	apsp_sts_t         sts;
	logic [IW-1:0]     idx_i, idx_j, idx_k, nm1;
	logic [NODE_W-1:0] out_src, out_dst;
	logic [DIST_W-1:0] out_dist;

	apsp_ctrl #(
		.MAX_NODES(MAX_NODES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_mode  (s_tuser[0]),
		.nm1      (nm1),
		.sts      (sts),
		.cmd      (cmd),
		.idx_i    (idx_i),
		.idx_j    (idx_j),
		.idx_k    (idx_k)
	);

	apsp_dpath #(
		.MAX_NODES(MAX_NODES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.idx_i     (idx_i),
		.idx_j     (idx_j),
		.idx_k     (idx_k),
		.nm1       (nm1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ld_row    (s_tdata[2:0]),
		.ld_col    (s_tdata[5:3]),
		.ld_weight (s_tdata[35:6]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_src   (out_src),
		.out_dst   (out_dst),
		.out_dist  (out_dist),
		.out_last  (m_tlast)
	);

	// Pack result fields
	assign m_tdata = {4'b0000, out_dist, out_dst, out_src};

endmodule

`default_nettype wire
